/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BQW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication after a fixed number of cycles
`define BQW_ASSERT_LAT(lbl, ante, n, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

/* design/bqw_pkg.sv */
// ----------------------------------------------------------------------------
// bqw_pkg
// Fixed field widths and register indexes of the quad warp address core.
// ----------------------------------------------------------------------------
package bqw_pkg;

    localparam int IN_W       = 5;   // out_col / out_row
    localparam int CORNER_W   = 24;  // corner register
    localparam int WIDTH_W    = 13;  // source_width register
    localparam int SRC_ADDR_W = 24;
    localparam int DEST_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_LEFT     = 3'd0,
        CFG_TOP_RIGHT    = 3'd1,
        CFG_BOTTOM_LEFT  = 3'd2,
        CFG_BOTTOM_RIGHT = 3'd3,
        CFG_SRC_WIDTH    = 3'd4
    } t_cfg_idx;

endpackage

/* design/bilinear_quad_warp_address_core.sv */
// ----------------------------------------------------------------------------
// bilinear_quad_warp_address_core
// Destination tile pixel to source image address, bilinear quad mapping.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: an item (i_out_col, i_out_row) is taken at a rising edge
//   with start high and busy low. busy is only high while i_rst_n is low;
//   otherwise one item can enter every clock.
//   Output channel: o_valid strobes for one cycle with o_src_address,
//   o_dest_address and o_column_overflow. The receiver cannot stall; the
//   pipeline never holds, so results leave in input order.
//   Pipeline: an accepted item moves through r_vld_s1, r_vld_s2, r_vld_s3
//   and then o_valid, whose strobe carries the item's result.
//   Throughput: 1 item per clock; no stage ever holds. Four register stages
//   (edge blend, cross blend, row multiply, address add), each at most one
//   multiplier deep.
//   Config port: i_cfg_we / i_cfg_idx / i_cfg_data, one register per edge;
//   the user must write only while no item is in flight, as the block does
//   not enforce it. Indexes past the list are ignored.
//   Reset (synchronous, active low): corners go to 0, source width to 1,
//   and all in-flight valid bits clear. No memories, no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bilinear_quad_warp_address_core #(
    parameter int TILE_SIZE  = 32,   // power of two, 2..1024
    parameter int COORD_BITS = 12    // 4..16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item in
    input  logic                              start,
    output logic                              busy,
    input  logic [bqw_pkg::IN_W-1:0]          i_out_col,
    input  logic [bqw_pkg::IN_W-1:0]          i_out_row,
    // result out
    output logic                              o_valid,
    output logic [bqw_pkg::SRC_ADDR_W-1:0]    o_src_address,
    output logic [bqw_pkg::DEST_W-1:0]        o_dest_address,
    output logic                              o_column_overflow,
    // config
    input  logic                              i_cfg_we,
    input  logic [bqw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bqw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int LOG_T = $clog2(TILE_SIZE);
    localparam int EXT_W = 2 * COORD_BITS;                 // x and y of a corner
    localparam int PROD_W = COORD_BITS + bqw_pkg::WIDTH_W; // row * width
    localparam int SUM_W  = PROD_W + 1;
    // coordinates are taken mod TILE_SIZE; no-op once the tile is 32 or more
    localparam logic [bqw_pkg::IN_W-1:0] IN_MASK =
        (TILE_SIZE >= 32) ? '1 : bqw_pkg::IN_W'(TILE_SIZE - 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [bqw_pkg::CORNER_W-1:0] r_tl, r_tr, r_bl, r_br;
    logic [bqw_pkg::WIDTH_W-1:0]  r_src_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tl        <= '0;
            r_tr        <= '0;
            r_bl        <= '0;
            r_br        <= '0;
            r_src_width <= bqw_pkg::WIDTH_W'(1);
        end else if (i_cfg_we) begin
            unique case (bqw_pkg::t_cfg_idx'(i_cfg_idx))
                bqw_pkg::CFG_TOP_LEFT:     r_tl <= i_cfg_data[bqw_pkg::CORNER_W-1:0];
                bqw_pkg::CFG_TOP_RIGHT:    r_tr <= i_cfg_data[bqw_pkg::CORNER_W-1:0];
                bqw_pkg::CFG_BOTTOM_LEFT:  r_bl <= i_cfg_data[bqw_pkg::CORNER_W-1:0];
                bqw_pkg::CFG_BOTTOM_RIGHT: r_br <= i_cfg_data[bqw_pkg::CORNER_W-1:0];
                bqw_pkg::CFG_SRC_WIDTH:    r_src_width <= i_cfg_data[bqw_pkg::WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // corner split: x low, y above it; bits past the register read as zero
    logic [EXT_W-1:0] w_tl_e, w_tr_e, w_bl_e, w_br_e;
    assign w_tl_e = EXT_W'(r_tl);
    assign w_tr_e = EXT_W'(r_tr);
    assign w_bl_e = EXT_W'(r_bl);
    assign w_br_e = EXT_W'(r_br);

    // ------------------------------------------------------------------
    // input: never held off except in reset
    // ------------------------------------------------------------------
    logic                         w_accept;
    logic [bqw_pkg::IN_W-1:0]     w_col, w_row;
    logic [bqw_pkg::DEST_W-1:0]   w_dest;

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;
    assign w_col    = i_out_col & IN_MASK;
    assign w_row    = i_out_row & IN_MASK;
    // row*T + col; col < T so the OR is the add, wraps mod 1024
    assign w_dest   = (bqw_pkg::DEST_W'(w_row) << LOG_T) | bqw_pkg::DEST_W'(w_col);

    // ------------------------------------------------------------------
    // stages 1-2: blend per axis (edge lerp, then cross lerp)
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] w_sx, w_sy;

    bqw_blend #(
        .TILE_SIZE  (TILE_SIZE),
        .COORD_BITS (COORD_BITS)
    ) u_blend_x (
        .i_clk   (i_clk),
        .i_tl    (w_tl_e[COORD_BITS-1:0]),
        .i_tr    (w_tr_e[COORD_BITS-1:0]),
        .i_bl    (w_bl_e[COORD_BITS-1:0]),
        .i_br    (w_br_e[COORD_BITS-1:0]),
        .i_col   (w_col),
        .i_row   (w_row),
        .o_coord (w_sx)
    );

    bqw_blend #(
        .TILE_SIZE  (TILE_SIZE),
        .COORD_BITS (COORD_BITS)
    ) u_blend_y (
        .i_clk   (i_clk),
        .i_tl    (w_tl_e[EXT_W-1:COORD_BITS]),
        .i_tr    (w_tr_e[EXT_W-1:COORD_BITS]),
        .i_bl    (w_bl_e[EXT_W-1:COORD_BITS]),
        .i_br    (w_br_e[EXT_W-1:COORD_BITS]),
        .i_col   (w_col),
        .i_row   (w_row),
        .o_coord (w_sy)
    );

    // valid and destination address ride alongside the blend and multiply stages
    logic                       r_vld_s1, r_vld_s2, r_vld_s3;
    logic [bqw_pkg::DEST_W-1:0] r_dest_s1, r_dest_s2, r_dest_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_s1 <= 1'b0;
            r_vld_s2 <= 1'b0;
            r_vld_s3 <= 1'b0;
        end else begin
            r_vld_s1 <= w_accept;
            r_vld_s2 <= r_vld_s1;
            r_vld_s3 <= r_vld_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dest_s1 <= w_dest;
        r_dest_s2 <= r_dest_s1;
        r_dest_s3 <= r_dest_s2;
    end

    // ------------------------------------------------------------------
    // stage 3: row * width, column range check
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]     r_prod;
    logic [COORD_BITS-1:0] r_sx;
    logic                  r_over;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_sy) * PROD_W'(r_src_width);
        r_sx   <= w_sx;
        // width zero makes every column overflow
        r_over <= (PROD_W'(w_sx) >= PROD_W'(r_src_width));
    end

    // ------------------------------------------------------------------
    // stage 4: address add, output register
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]               w_sum;
    logic [bqw_pkg::SRC_ADDR_W-1:0] n_src_address;

    assign w_sum         = SUM_W'(r_prod) + SUM_W'(r_sx);
    assign n_src_address = r_over ? '0 : bqw_pkg::SRC_ADDR_W'(w_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        o_src_address     <= n_src_address;
        o_dest_address    <= r_dest_s3;
        o_column_overflow <= r_over;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `BQW_ASSERT_LAT(a_item_out, w_accept, 4, o_valid, "accepted item lost")
    `BQW_ASSERT_LAT(a_no_phantom, !w_accept, 4, !o_valid, "result without item")
    `BQW_ASSERT_IMP(a_over_zero, o_valid & o_column_overflow, ~|o_src_address, "overflow address")
    `BQW_ASSERT_IMP(a_width_zero, o_valid & ~|r_src_width, o_column_overflow, "zero width")

endmodule

/* design/bqw_blend.sv */
// ----------------------------------------------------------------------------
// bqw_blend
// Two-stage exact bilinear blend of one coordinate axis, floor of num / T^2.
// ----------------------------------------------------------------------------
module bqw_blend #(
    parameter int TILE_SIZE  = 32,
    parameter int COORD_BITS = 12
) (
    input  logic                        i_clk,
    input  logic [COORD_BITS-1:0]       i_tl,
    input  logic [COORD_BITS-1:0]       i_tr,
    input  logic [COORD_BITS-1:0]       i_bl,
    input  logic [COORD_BITS-1:0]       i_br,
    input  logic [bqw_pkg::IN_W-1:0]    i_col,   // already reduced mod TILE_SIZE
    input  logic [bqw_pkg::IN_W-1:0]    i_row,
    output logic [COORD_BITS-1:0]       o_coord
);

    localparam int LOG_T = $clog2(TILE_SIZE);
    localparam int TW    = LOG_T + 1;              // holds 0..TILE_SIZE
    localparam int EW    = COORD_BITS + TW;        // edge value, < 2^CB * T
    localparam int NW    = COORD_BITS + 2 * TW;    // blended numerator

    logic [TW-1:0] w_c, w_tc, w_r, w_tr;
    logic [EW-1:0] w_top, w_bot;
    logic [NW-1:0] w_num;

    logic [EW-1:0] r_top, r_bot;
    logic [TW-1:0] r_r, r_tr;

    assign w_c  = TW'(i_col);
    assign w_r  = TW'(i_row);
    assign w_tc = TW'(TILE_SIZE) - w_c;
    assign w_tr = TW'(TILE_SIZE) - w_r;

    // stage A: interpolate along top and bottom edges
    assign w_top = EW'(i_tl) * EW'(w_tc) + EW'(i_tr) * EW'(w_c);
    assign w_bot = EW'(i_bl) * EW'(w_tc) + EW'(i_br) * EW'(w_c);

    always_ff @(posedge i_clk) begin
        r_top <= w_top;
        r_bot <= w_bot;
        r_r   <= w_r;
        r_tr  <= w_tr;
    end

    // stage B: interpolate between edges, divide by T^2 as a shift
    assign w_num = NW'(r_top) * NW'(r_tr) + NW'(r_bot) * NW'(r_r);

    always_ff @(posedge i_clk) begin
        o_coord <= w_num[2*LOG_T +: COORD_BITS];
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quad warp address core: drives tile pixel
// items, predicts source and destination addresses from a shadow copy of the
// corner and width registers, and checks every strobed result in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TILE       = 32;
    localparam int COORD_BITS = 12;
    localparam int TAIL_CYCLES = 8;        // pipeline is 4 deep, plus margin
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 92;
    localparam int RANDOM_PHASES = 6;
    localparam logic [bqw_pkg::CFG_IDX_W-1:0] CFG_IDX_LAST = '1;

    typedef struct packed {
        logic [bqw_pkg::SRC_ADDR_W-1:0] src_address;
        logic [bqw_pkg::DEST_W-1:0]     dest_address;
        logic                           column_overflow;
    } t_warp_result;

    // DUT signals; the driven inputs are known from time zero
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [bqw_pkg::IN_W-1:0]       i_out_col = '0;
    logic [bqw_pkg::IN_W-1:0]       i_out_row = '0;
    logic                           o_valid;
    logic [bqw_pkg::SRC_ADDR_W-1:0] o_src_address;
    logic [bqw_pkg::DEST_W-1:0]     o_dest_address;
    logic                           o_column_overflow;
    logic                           i_cfg_we = 1'b0;
    logic [bqw_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [bqw_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // shadow registers, reset values
    logic [bqw_pkg::CORNER_W-1:0] shadow_corner [4] = '{default: '0};
    logic [bqw_pkg::WIDTH_W-1:0]  shadow_width = bqw_pkg::WIDTH_W'(1);

    t_warp_result pending_addr_q [$];
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count = 0;

    bilinear_quad_warp_address_core #(
        .TILE_SIZE  (TILE),
        .COORD_BITS (COORD_BITS)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_out_col         (i_out_col),
        .i_out_row         (i_out_row),
        .o_valid           (o_valid),
        .o_src_address     (o_src_address),
        .o_dest_address    (o_dest_address),
        .o_column_overflow (o_column_overflow),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop if the run hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Address prediction
    // ------------------------------------------------------------------

    // floor of the exact bilinear blend; all terms non-negative
    function automatic longint unsigned blend_axis(
        input longint unsigned tl, tr, bl, br, c, r
    );
        longint unsigned top, bot, num;
        top = tl * (TILE - c) + tr * c;
        bot = bl * (TILE - c) + br * c;
        num = top * (TILE - r) + bot * r;
        return num / (TILE * TILE);
    endfunction

    function automatic longint unsigned corner_x(
        input logic [bqw_pkg::CORNER_W-1:0] reg_val
    );
        return longint'(reg_val[COORD_BITS-1:0]);
    endfunction

    function automatic longint unsigned corner_y(
        input logic [bqw_pkg::CORNER_W-1:0] reg_val
    );
        return longint'(reg_val[2*COORD_BITS-1:COORD_BITS]);
    endfunction

    function automatic t_warp_result predict_warp_address(
        input logic [bqw_pkg::IN_W-1:0] col, row
    );
        longint unsigned c, r, sx, sy, w, lin;
        t_warp_result    res;
        c = col % TILE;
        r = row % TILE;
        sx = blend_axis(corner_x(shadow_corner[2'(bqw_pkg::CFG_TOP_LEFT)]),
                        corner_x(shadow_corner[2'(bqw_pkg::CFG_TOP_RIGHT)]),
                        corner_x(shadow_corner[2'(bqw_pkg::CFG_BOTTOM_LEFT)]),
                        corner_x(shadow_corner[2'(bqw_pkg::CFG_BOTTOM_RIGHT)]), c, r);
        sy = blend_axis(corner_y(shadow_corner[2'(bqw_pkg::CFG_TOP_LEFT)]),
                        corner_y(shadow_corner[2'(bqw_pkg::CFG_TOP_RIGHT)]),
                        corner_y(shadow_corner[2'(bqw_pkg::CFG_BOTTOM_LEFT)]),
                        corner_y(shadow_corner[2'(bqw_pkg::CFG_BOTTOM_RIGHT)]), c, r);
        w = longint'(shadow_width);
        lin = sy * w + sx;
        // column at or past the row width (width zero included) reads nothing
        res.column_overflow = (sx >= w);
        res.src_address     = res.column_overflow ? '0 : bqw_pkg::SRC_ADDR_W'(lin);
        res.dest_address    = bqw_pkg::DEST_W'(r * TILE + c);
        return res;
    endfunction

    function automatic logic [bqw_pkg::CORNER_W-1:0] pack_corner(input int unsigned x, y);
        return {COORD_BITS'(y), COORD_BITS'(x)};
    endfunction

    // ------------------------------------------------------------------
    // Result checker: one strobe, one compare against the oldest entry
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_warp_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_addr_q.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("[%0t] result with nothing pending: src=%h dest=%h ovf=%b",
                             $realtime, o_src_address, o_dest_address, o_column_overflow);
            end else begin
                want = pending_addr_q.pop_front();
                if (o_src_address !== want.src_address ||
                    o_dest_address !== want.dest_address ||
                    o_column_overflow !== want.column_overflow) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("[%0t] exp src %h dest %h ovf %b, got %h %h %b",
                                 $realtime, want.src_address, want.dest_address,
                                 want.column_overflow, o_src_address,
                                 o_dest_address, o_column_overflow);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drive helpers
    // ------------------------------------------------------------------

    // start stays high across back-to-back items; only idle_burst or
    // drain_pipeline lower it
    task automatic send_pixel(input logic [bqw_pkg::IN_W-1:0] col, row);
        start     <= 1'b1;
        i_out_col <= col;
        i_out_row <= row;
        do @(posedge i_clk); while (busy);
        pending_addr_q.push_back(predict_warp_address(col, row));
    endtask

    task automatic idle_burst(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic feed_pixel(input logic [bqw_pkg::IN_W-1:0] col, row,
                              input bit allow_idle);
        if (allow_idle && $urandom_range(0, 3) == 0)
            idle_burst($urandom_range(1, 13));
        send_pixel(col, row);
    endtask

    // stop sending and let every pending item come out
    task automatic drain_pipeline();
        start <= 1'b0;
        while (pending_addr_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // caller lowers i_cfg_we once its writes are done
    task automatic write_reg(input logic [bqw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bqw_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            bqw_pkg::CFG_TOP_LEFT, bqw_pkg::CFG_TOP_RIGHT,
            bqw_pkg::CFG_BOTTOM_LEFT, bqw_pkg::CFG_BOTTOM_RIGHT:
                shadow_corner[idx[1:0]] = data;
            bqw_pkg::CFG_SRC_WIDTH:
                shadow_width = data[bqw_pkg::WIDTH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_quad(input logic [bqw_pkg::CORNER_W-1:0] tl, tr, bl, br,
                                input logic [bqw_pkg::WIDTH_W-1:0] width);
        drain_pipeline();
        write_reg(bqw_pkg::CFG_TOP_LEFT, tl);
        write_reg(bqw_pkg::CFG_TOP_RIGHT, tr);
        write_reg(bqw_pkg::CFG_BOTTOM_LEFT, bl);
        write_reg(bqw_pkg::CFG_BOTTOM_RIGHT, br);
        // junk above the width field must not matter
        write_reg(bqw_pkg::CFG_SRC_WIDTH,
                  {(bqw_pkg::CFG_DATA_W - bqw_pkg::WIDTH_W)'($urandom), width});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // corners all zero, width one: everything maps to source pixel 0
    task automatic test_reset_defaults();
        send_pixel(bqw_pkg::IN_W'(0), bqw_pkg::IN_W'(0));
        send_pixel(bqw_pkg::IN_W'(31), bqw_pkg::IN_W'(31));
    endtask

    // every coordinate at its maximum, widest width field; address wraps
    task automatic test_corner_extremes();
        program_quad('1, '1, '1, '1, '1);
        send_pixel(bqw_pkg::IN_W'(0), bqw_pkg::IN_W'(0));
        send_pixel(bqw_pkg::IN_W'(31), bqw_pkg::IN_W'(0));
        send_pixel(bqw_pkg::IN_W'(0), bqw_pkg::IN_W'(31));
        send_pixel(bqw_pkg::IN_W'(31), bqw_pkg::IN_W'(31));
    endtask

    task automatic test_column_overflow();
        program_quad(pack_corner(0, 0), pack_corner(200, 10),
                     pack_corner(20, 300), pack_corner(250, 320),
                     bqw_pkg::WIDTH_W'(100));
        send_pixel(bqw_pkg::IN_W'(0), bqw_pkg::IN_W'(0));
        send_pixel(bqw_pkg::IN_W'(31), bqw_pkg::IN_W'(0));
        send_pixel(bqw_pkg::IN_W'(16), bqw_pkg::IN_W'(16));
        send_pixel(bqw_pkg::IN_W'(5), bqw_pkg::IN_W'(31));
        // column exactly at the width, then one inside it
        program_quad(pack_corner(100, 5), pack_corner(100, 5),
                     pack_corner(100, 5), pack_corner(100, 5),
                     bqw_pkg::WIDTH_W'(100));
        send_pixel(bqw_pkg::IN_W'(7), bqw_pkg::IN_W'(9));
        program_quad(pack_corner(100, 5), pack_corner(100, 5),
                     pack_corner(100, 5), pack_corner(100, 5),
                     bqw_pkg::WIDTH_W'(101));
        send_pixel(bqw_pkg::IN_W'(7), bqw_pkg::IN_W'(9));
    endtask

    // width zero: every column overflows
    task automatic test_width_zero();
        program_quad(pack_corner(0, 0), pack_corner(0, 0),
                     pack_corner(0, 7), pack_corner(0, 7), bqw_pkg::WIDTH_W'(0));
        send_pixel(bqw_pkg::IN_W'(0), bqw_pkg::IN_W'(0));
        send_pixel(bqw_pkg::IN_W'(31), bqw_pkg::IN_W'(17));
        send_pixel(bqw_pkg::IN_W'(10), bqw_pkg::IN_W'(31));
    endtask

    // writes to indexes past the register list change nothing
    task automatic test_ignored_index();
        program_quad(pack_corner(12, 3), pack_corner(900, 40),
                     pack_corner(30, 700), pack_corner(1000, 800),
                     bqw_pkg::WIDTH_W'(4096));
        for (int k = bqw_pkg::CFG_SRC_WIDTH + 1; k <= CFG_IDX_LAST; k++)
            write_reg(bqw_pkg::CFG_IDX_W'(k), '1);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        send_pixel(bqw_pkg::IN_W'(3), bqw_pkg::IN_W'(28));
        send_pixel(bqw_pkg::IN_W'(31), bqw_pkg::IN_W'(1));
        send_pixel(bqw_pkg::IN_W'(20), bqw_pkg::IN_W'(20));
    endtask

    // random quads and widths, random pixels, random gaps but in the last phase
    task automatic test_random_warp();
        logic [bqw_pkg::CORNER_W-1:0] corner [4];
        logic [bqw_pkg::WIDTH_W-1:0]  width;
        int unsigned                  shape, max_x;
        bit                           allow_idle;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            shape = $urandom_range(0, 2);
            // narrow quads give mostly in-range columns, wide ones a mix
            max_x = (shape == 1) ? 255 : 4095;
            for (int k = 0; k < 4; k++)
                corner[2'(k)] = pack_corner($urandom_range(0, max_x),
                                            $urandom_range(0, 4095));
            case ($urandom_range(0, 9))
                0:       width = '0;
                1:       width = bqw_pkg::WIDTH_W'($urandom_range(4097, 8191));
                2, 3:    width = bqw_pkg::WIDTH_W'(4096);
                default: width = bqw_pkg::WIDTH_W'($urandom_range(1, max_x + 1));
            endcase
            program_quad(corner[0], corner[1], corner[2], corner[3], width);
            // last phase runs flat out
            allow_idle = (ph != RANDOM_PHASES - 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // one mid-phase pause until everything has come out
                if (ph == 1 && n == 45)
                    drain_pipeline();
                feed_pixel(bqw_pkg::IN_W'($urandom), bqw_pkg::IN_W'($urandom),
                           allow_idle);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_corner_extremes();
        test_column_overflow();
        test_width_zero();
        test_ignored_index();
        test_random_warp();

        drain_pipeline();
        if (mismatch_count == 0 && pending_addr_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
